### sv/sad_pkg.sv
`timescale 1ns / 1ps
// sad_pkg: shared sizes, command and status codes and cell operations
// for the shifting array deque; no dependencies
package sad_pkg;

  localparam int DEPTH     = 16;
  localparam int ELEM_BITS = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // fixed port widths
  localparam int CMD_W    = 4;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_POLL_FRONT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_POLL_BACK  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_GET_FIRST  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_GET_LAST   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PEEK_FIRST = 4'd8;
  localparam logic [CMD_W-1:0] CMD_PEEK_LAST  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_RM_FIRST   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_RM_LAST    = 4'd11;
  localparam logic [CMD_W-1:0] CMD_CONTAINS   = 4'd12;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd13;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_NULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_TAKE_LOWER,
    OP_TAKE_UPPER,
    OP_CLEAR
  } cell_op_t;

endpackage

### sv/sad_cell.sv
`timescale 1ns / 1ps
// sad_cell: one element cell of the deque, shifts to or from its neighbours
// depends on sad_pkg
module sad_cell
  import sad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cell_op_t op,
  input  elem_t    new_val,
  input  elem_t    lower_val,
  input  elem_t    upper_val,
  input  elem_t    target,
  output elem_t    elem,
  output logic     hit
);

  elem_t elem_r;
  elem_t elem_nxt;

  always_comb begin
    case (op)
      OP_LOAD:       elem_nxt = new_val;
      OP_TAKE_LOWER: elem_nxt = lower_val;
      OP_TAKE_UPPER: elem_nxt = upper_val;
      OP_CLEAR:      elem_nxt = '0;
      default:       elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r <= '0;
    end else begin
      elem_r <= elem_nxt;
    end
  end

  // null never sits in a live cell, so a null target never matches
  assign hit  = (target != '0) && (elem_r == target);
  assign elem = elem_r;

endmodule

### sv/shifting_array_deque.sv
`timescale 1ns / 1ps
// shifting_array_deque: bounded double-ended queue built from a row of cells
// depends on sad_pkg and sad_cell
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  command  | in_cmd, in_item_value                   | start, busy
//  result   | out_value, out_found, out_status,       | out_strobe, one cycle
//           | out_count, out_is_empty                 |
//
// one command word is taken in every cycle; busy stays low
// the word is executed at the accepting edge: all cells compare against the
// target in parallel and shift in the same edge, so the result word shows on
// the result ports in the next cycle, marked by out_strobe for that cycle only
// reset clears every cell to null and the count to zero
// the receiver cannot stall, so nothing is ever held back
module shifting_array_deque
  import sad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [VAL_W-1:0]     in_item_value,
  output logic                 out_strobe,
  output logic [VAL_W-1:0]     out_value,
  output logic                 out_found,
  output logic [ST_W-1:0]      out_status,
  output logic [CNT_OUT_W-1:0] out_count,
  output logic                 out_is_empty
);

  // ---------------------------------------------------------------- state
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] held_nxt;

  logic                 out_strobe_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 out_found_r;
  logic [ST_W-1:0]      out_status_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_is_empty_r;

  logic accept;

  // ---------------------------------------------------------------- cell row
  elem_t            cell_q   [DEPTH];
  cell_op_t         cell_op  [DEPTH];
  logic [DEPTH-1:0] hits;
  elem_t            val;
  logic [63:0]      val_wide;

  // incoming word cut or padded to element width
  assign val_wide = 64'(in_item_value);
  assign val      = val_wide[ELEM_BITS-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    elem_t lower_v;
    elem_t upper_v;
    if (g == 0) begin : g_first
      assign lower_v = '0;
    end else begin : g_mid_lo
      assign lower_v = cell_q[g-1];
    end
    // past the top cell everything is null, so a removal pulls in zero
    if (g == DEPTH - 1) begin : g_last
      assign upper_v = '0;
    end else begin : g_mid_hi
      assign upper_v = cell_q[g+1];
    end
    sad_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (cell_op[g]),
      .new_val   (val),
      .lower_val (lower_v),
      .upper_val (upper_v),
      .target    (val),
      .elem      (cell_q[g]),
      .hit       (hits[g])
    );
  end

  // ---------------------------------------------------------------- search
  logic             any_hit;
  logic [DEPTH-1:0] first_mask;   // at or above the first match
  logic [DEPTH-1:0] last_mask;    // at or above the last match
  logic [DEPTH-1:0] live;         // cells below the count
  logic [IDX_W-1:0] back_idx;
  logic [CNT_W-1:0] held_dec;
  elem_t            front_elem;
  elem_t            back_elem;

  assign any_hit = |hits;

  always_comb begin
    logic acc_lo;
    logic acc_hi;
    acc_lo = 1'b0;
    acc_hi = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      acc_lo        = acc_lo | hits[k];
      first_mask[k] = acc_lo;
      live[k]       = CNT_W'(k) < held_r;
    end
    // a cell sits at or above the last match when no match lies above it
    for (int k = DEPTH - 1; k >= 0; k--) begin
      last_mask[k] = any_hit & ~acc_hi;
      acc_hi       = acc_hi | hits[k];
    end
  end

  assign held_dec   = held_r - 1'b1;
  assign back_idx   = held_dec[IDX_W-1:0];
  assign front_elem = cell_q[0];
  assign back_elem  = cell_q[back_idx];

  // ---------------------------------------------------------------- decode
  elem_t            res_val;
  logic             res_found;
  logic [ST_W-1:0]  res_status;
  logic             go_push_front;
  logic             go_push_back;
  logic             go_remove;
  logic             go_clear;
  logic [DEPTH-1:0] rm_mask;

  always_comb begin
    res_val       = '0;
    res_found     = 1'b0;
    res_status    = ST_OK;
    held_nxt      = held_r;
    go_push_front = 1'b0;
    go_push_back  = 1'b0;
    go_remove     = 1'b0;
    go_clear      = 1'b0;
    rm_mask       = '0;
    unique case (in_cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        // null is refused before the full check
        if (val == '0) begin
          res_status = ST_NULL;
        end else if (held_r == CNT_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_found     = 1'b1;
          held_nxt      = held_r + 1'b1;
          go_push_front = (in_cmd == CMD_PUSH_FRONT);
          go_push_back  = (in_cmd == CMD_PUSH_BACK);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_POLL_FRONT, CMD_POLL_BACK: begin
        if (held_r == '0) begin
          // strict pop reports an error, soft poll quietly returns null
          if (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK) begin
            res_status = ST_EMPTY;
          end
        end else begin
          res_found = 1'b1;
          held_nxt  = held_dec;
          go_remove = 1'b1;
          if (in_cmd == CMD_POP_BACK || in_cmd == CMD_POLL_BACK) begin
            res_val = back_elem;
            for (int k = 0; k < DEPTH; k++) begin
              rm_mask[k] = (CNT_W'(k) == held_dec);
            end
          end else begin
            res_val = front_elem;
            rm_mask = '1;
          end
        end
      end
      CMD_GET_FIRST, CMD_GET_LAST, CMD_PEEK_FIRST, CMD_PEEK_LAST: begin
        if (held_r == '0) begin
          if (in_cmd == CMD_GET_FIRST || in_cmd == CMD_GET_LAST) begin
            res_status = ST_EMPTY;
          end
        end else if (in_cmd == CMD_GET_LAST || in_cmd == CMD_PEEK_LAST) begin
          res_val = back_elem;
        end else begin
          res_val = front_elem;
        end
      end
      CMD_RM_FIRST, CMD_RM_LAST: begin
        if (any_hit) begin
          res_found = 1'b1;
          held_nxt  = held_dec;
          go_remove = 1'b1;
          rm_mask   = (in_cmd == CMD_RM_LAST) ? last_mask : first_mask;
        end
      end
      CMD_CONTAINS: begin
        res_found = any_hit;
      end
      CMD_CLEAR: begin
        go_clear = 1'b1;
        held_nxt = '0;
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
  end

  // per-cell operation; nothing moves unless a word is taken
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_op[k] = OP_HOLD;
      if (accept) begin
        if (go_clear) begin
          cell_op[k] = OP_CLEAR;
        end else if (go_push_front) begin
          if (k == 0) begin
            cell_op[k] = OP_LOAD;
          end else if (CNT_W'(k) <= held_r) begin
            cell_op[k] = OP_TAKE_LOWER;
          end
        end else if (go_push_back) begin
          if (CNT_W'(k) == held_r) begin
            cell_op[k] = OP_LOAD;
          end
        end else if (go_remove && rm_mask[k] && live[k]) begin
          cell_op[k] = OP_TAKE_UPPER;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [63:0] res_wide;
  logic [31:0] cnt_wide;

  assign accept   = start && !busy;
  assign res_wide = 64'(res_val);
  assign cnt_wide = 32'(held_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r    <= res_wide[VAL_W-1:0];
      out_found_r    <= res_found;
      out_status_r   <= res_status;
      out_count_r    <= cnt_wide[CNT_OUT_W-1:0];
      out_is_empty_r <= (held_nxt == '0);
    end
  end

  assign busy         = 1'b0;
  assign out_strobe   = out_strobe_r;
  assign out_value    = out_value_r;
  assign out_found    = out_found_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;

  // ---------------------------------------------------------------- checks
  a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("element count beyond capacity");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted word gave no result");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result without a command");

  a_full_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> held_r == CNT_W'(DEPTH))
    else $error("full refusal with room left");

  a_found_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_found && go_remove) |=> held_r == $past(held_dec))
    else $error("removal did not shrink the count");

endmodule

### verif/deque_checker_pkg.sv
`timescale 1ns / 1ps
// deque_checker_pkg: shadow deque and awaited result words for the deque bench
// depends on sad_pkg
package deque_checker_pkg;
  import sad_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic                 found;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;
  } deque_word_t;

  class deque_checker;
    elem_t       mirror_cells[DEPTH];
    int          mirror_held;
    deque_word_t awaited_words[$];
    int          mismatch_count;

    function new();
      foreach (mirror_cells[k]) mirror_cells[k] = '0;
      mirror_held    = 0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    // null is never stored, so a null target never matches
    function int locate(elem_t target, bit from_back);
      if (target == '0) return -1;
      if (!from_back) begin
        for (int k = 0; k < mirror_held; k++)
          if (mirror_cells[k] == target) return k;
      end else begin
        for (int k = mirror_held - 1; k >= 0; k--)
          if (mirror_cells[k] == target) return k;
      end
      return -1;
    endfunction

    function void drop_at(int pos);
      for (int k = pos; k + 1 < mirror_held; k++) mirror_cells[k] = mirror_cells[k + 1];
      mirror_cells[mirror_held - 1] = '0;
      mirror_held--;
    endfunction

    // apply one accepted command word to the shadow and queue its result word
    function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] item);
      elem_t       val;
      deque_word_t w;
      int          pos;
      val      = elem_t'(item);
      w        = '0;
      w.status = ST_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (val == '0) begin
            w.status = ST_NULL;
          end else if (mirror_held >= DEPTH) begin
            w.status = ST_FULL;
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              for (int k = mirror_held; k > 0; k--) mirror_cells[k] = mirror_cells[k - 1];
              mirror_cells[0] = val;
            end else begin
              mirror_cells[mirror_held] = val;
            end
            mirror_held++;
            w.found = 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_POLL_FRONT, CMD_POLL_BACK: begin
          if (mirror_held == 0) begin
            if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) w.status = ST_EMPTY;
          end else begin
            pos     = (cmd == CMD_POP_BACK || cmd == CMD_POLL_BACK) ? mirror_held - 1 : 0;
            w.value = VAL_W'(mirror_cells[pos]);
            drop_at(pos);
            w.found = 1'b1;
          end
        end
        CMD_GET_FIRST, CMD_GET_LAST, CMD_PEEK_FIRST, CMD_PEEK_LAST: begin
          if (mirror_held == 0) begin
            if (cmd == CMD_GET_FIRST || cmd == CMD_GET_LAST) w.status = ST_EMPTY;
          end else begin
            pos     = (cmd == CMD_GET_LAST || cmd == CMD_PEEK_LAST) ? mirror_held - 1 : 0;
            w.value = VAL_W'(mirror_cells[pos]);
          end
        end
        CMD_RM_FIRST, CMD_RM_LAST: begin
          pos = locate(val, cmd == CMD_RM_LAST);
          if (pos >= 0) begin
            drop_at(pos);
            w.found = 1'b1;
          end
        end
        CMD_CONTAINS: w.found = (locate(val, 1'b0) >= 0);
        CMD_CLEAR: begin
          foreach (mirror_cells[k]) mirror_cells[k] = '0;
          mirror_held = 0;
        end
        default: ;
      endcase
      w.count    = CNT_OUT_W'(mirror_held);
      w.is_empty = (mirror_held == 0);
      awaited_words.push_back(w);
    endfunction

    function void check_word(logic [VAL_W-1:0] value, logic found, logic [ST_W-1:0] status,
                             logic [CNT_OUT_W-1:0] count, logic is_empty);
      deque_word_t w;
      if (awaited_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: value=%h found=%b status=%0d count=%0d empty=%b",
                   value, found, status, count, is_empty);
        return;
      end
      w = awaited_words.pop_front();
      if (value !== w.value || found !== w.found || status !== w.status ||
          count !== w.count || is_empty !== w.is_empty) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch: expected value=%h found=%b status=%0d count=%0d empty=%b",
                   w.value, w.found, w.status, w.count, w.is_empty);
          $display("                 actual   value=%h found=%b status=%0d count=%0d empty=%b",
                   value, found, status, count, is_empty);
        end
      end
    endfunction
  endclass

endpackage

### verif/tb_shifting_array_deque.sv
`timescale 1ns / 1ps
// tb_shifting_array_deque: self-checking bench for the shifting array deque
// depends on sad_pkg, deque_checker_pkg and shifting_array_deque
module tb_shifting_array_deque;
  import sad_pkg::*;
  import deque_checker_pkg::*;

  // codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd14;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MAX_GAP       = 20;

  typedef enum logic [1:0] {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} deque_mood_t;

  // every input known from time zero
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  logic [CMD_W-1:0]     in_cmd        = CMD_CLEAR;
  logic [VAL_W-1:0]     in_item_value = '0;
  logic                 busy;
  logic                 out_strobe;
  logic [VAL_W-1:0]     out_value;
  logic                 out_found;
  logic [ST_W-1:0]      out_status;
  logic [CNT_OUT_W-1:0] out_count;
  logic                 out_is_empty;

  int unsigned  cycle_count = 0;
  deque_checker scoreboard  = new();

  shifting_array_deque dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_item_value(in_item_value),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_found    (out_found),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_empty (out_is_empty)
  );

  // 12 ns period, 6 ns each half
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost result word ends here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result words are only valid for their single strobe cycle, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      scoreboard.check_word(out_value, out_found, out_status, out_count, out_is_empty);
  end

  // present one command word from the falling edge and hold it until accepted
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    @(negedge clk);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_item_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    scoreboard.note_command(cmd, val);
  endtask

  // sender gap with start low; n sets its length
  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender waits until every awaited result word has come back
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  // mostly a small pool of values so searches and removals hit, with
  // some null, some near the top of the range and some fully random
  function automatic logic [VAL_W-1:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 65) return VAL_W'($urandom_range(1, 6));
    if (r < 80) return {{(VAL_W-4){1'b1}}, 4'($urandom_range(0, 15))};
    return VAL_W'($urandom());
  endfunction

  // random traffic in moods that drive the store towards full or empty, or mix the two
  task automatic run_random_phase(input int sender_idle_pct, input int words_wanted);
    int               done;
    int               mood_left;
    int               push_pct;
    int               r;
    int               gap;
    deque_mood_t      mood;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    done      = 0;
    mood_left = 0;
    mood      = MOOD_MIXED;
    while (done < words_wanted) begin
      if (mood_left == 0) begin
        mood      = deque_mood_t'($urandom_range(0, 2));
        mood_left = $urandom_range(10, 50);
      end
      mood_left--;
      case (mood)
        MOOD_FILL:  push_pct = 70;
        MOOD_DRAIN: push_pct = 15;
        default:    push_pct = 45;
      endcase
      r   = $urandom_range(0, 99);
      val = pick_element();
      if (r < 2)
        cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      else if (r < 4)
        cmd = CMD_CLEAR;
      else if (r < 4 + push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        // pop front up to contains are consecutive codes
        cmd = CMD_POP_FRONT + CMD_W'($urandom_range(0, CMD_CONTAINS - CMD_POP_FRONT));
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) hold_off(gap);
      send_word(cmd, val);
      if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) done++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // strict and soft access on an empty store
    send_word(CMD_POP_FRONT,  '0);
    send_word(CMD_POP_BACK,   '0);
    send_word(CMD_POLL_FRONT, '0);
    send_word(CMD_POLL_BACK,  '0);
    send_word(CMD_GET_FIRST,  '0);
    send_word(CMD_GET_LAST,   '0);
    send_word(CMD_PEEK_FIRST, '0);
    send_word(CMD_PEEK_LAST,  '0);
    send_word(CMD_RM_FIRST,   32'd5);
    send_word(CMD_CONTAINS,   '0);
    // null push refused, then extremes and duplicates
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_PUSH_BACK,  32'hFFFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'd1);
    send_word(CMD_PUSH_BACK,  32'd7);
    send_word(CMD_PUSH_FRONT, 32'd7);
    send_word(CMD_PUSH_BACK,  32'd7);
    // removal from either end of the duplicates, and a null target
    send_word(CMD_RM_LAST,    32'd7);
    send_word(CMD_RM_FIRST,   32'd7);
    send_word(CMD_RM_FIRST,   '0);
    send_word(CMD_CONTAINS,   32'hFFFF_FFFF);
    send_word(CMD_CONTAINS,   32'd8);
    // ignored codes leave the store as it is
    send_word(CMD_SPARE_LO,   32'h8000_0000);
    send_word(CMD_SPARE_HI,   32'h8000_0000);
    send_word(CMD_PEEK_LAST,  '0);
    send_word(CMD_CLEAR,      '0);
    wait_until_drained();

    // sender idles about a third of the time, then about half, then never
    run_random_phase(34, 600);
    wait_until_drained();
    run_random_phase(55, 600);
    wait_until_drained();
    run_random_phase(0, 600);
    wait_until_drained();

    // room for any stray result word after the last one awaited
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
